@@ hw/rtl/rxfsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rxfsi_pkg
// Shared types and constants of the receive FIFO with status and interrupts.
// ----------------------------------------------------------------------------
package rxfsi_pkg;

    localparam int WORD_W  = 32;
    localparam int FILL_W  = 9;
    localparam int MASK_W  = 3;
    localparam int LEVEL_W = 9;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [LEVEL_W-1:0] HALF_LEVEL_RST = LEVEL_W'(128);

    // Bit positions in the interrupt mask.
    localparam int MASK_NOT_EMPTY = 0;
    localparam int MASK_HALF      = 1;
    localparam int MASK_FULL      = 2;

    // Register indexes, taken from the word address.
    localparam logic REG_IRQ_MASK   = 1'b0;
    localparam logic REG_HALF_LEVEL = 1'b1;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_POLL   = 2'd2,
        CMD_STATUS = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CAUSE_NONE      = 2'd0,
        CAUSE_NOT_EMPTY = 2'd1,
        CAUSE_HALF      = 2'd2,
        CAUSE_FULL      = 2'd3
    } t_cause;

    typedef struct packed {
        t_cmd              cmd;
        logic [WORD_W-1:0] word_in;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] word_out;
        logic              word_valid;
        logic              accepted;
        logic              flag_empty;
        logic              flag_half;
        logic              flag_full;
        logic              flag_overrun;
        logic              flag_present;
        t_cause            irq_cause;
        logic [FILL_W-1:0] fill_level;
    } t_out_item;

    typedef struct packed {
        logic [MASK_W-1:0]  irq_mask;
        logic [LEVEL_W-1:0] half_level;
    } t_cfg;

endpackage

@@ hw/rtl/rx_fifo_status_interrupts_core.sv @@
// ----------------------------------------------------------------------------
// rx_fifo_status_interrupts_core
// Receive FIFO of 32-bit words with status flags and maskable interrupts.
//
//   channel   direction  handshake                    payload
//   input     in         i_in_valid / o_in_ready      i_in_item  (t_in_item)
//   output    out        o_out_valid / i_out_ready    o_out_item (t_out_item)
//   config    in         psel, penable, pwrite        paddr, pwdata, prdata
//
// One item is taken per cycle while the output does not stall; its result is
// registered in the pending stage, beside the registered read of the word
// store, and then in the output stage. Reset is synchronous and needs no
// clearing pass: the store is only read where it was written. A stalled output
// holds the pending item; the input is refused until the pending stage can move on.
// ----------------------------------------------------------------------------
module rx_fifo_status_interrupts_core #(
    parameter int DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rxfsi_pkg::t_in_item           i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rxfsi_pkg::t_out_item          o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rxfsi_pkg::APB_AW-1:0]  paddr,
    input  logic [rxfsi_pkg::APB_DW-1:0]  pwdata,
    output logic [rxfsi_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rxfsi_pkg::t_cfg              cfg;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [rxfsi_pkg::WORD_W-1:0] wr_data;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [rxfsi_pkg::WORD_W-1:0] rd_data;

    rxfsi_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rxfsi_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rxfsi_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

endmodule

@@ hw/rtl/rxfsi_mem.sv @@
// ----------------------------------------------------------------------------
// rxfsi_mem
// Word store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rxfsi_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [rxfsi_pkg::WORD_W-1:0]  i_wr_data,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [rxfsi_pkg::WORD_W-1:0]  o_rd_data
);

    logic [rxfsi_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [rxfsi_pkg::WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/rxfsi_apb.sv @@
// ----------------------------------------------------------------------------
// rxfsi_apb
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module rxfsi_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rxfsi_pkg::APB_AW-1:0]  paddr,
    input  logic [rxfsi_pkg::APB_DW-1:0]  pwdata,
    output logic [rxfsi_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    output rxfsi_pkg::t_cfg               o_cfg
);

    logic [rxfsi_pkg::MASK_W-1:0]  r_irq_mask;
    logic [rxfsi_pkg::LEVEL_W-1:0] r_half_level;
    logic                          wr_stb;
    logic                          reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_stb  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_mask   <= '0;
            r_half_level <= rxfsi_pkg::HALF_LEVEL_RST;
        end else if (wr_stb) begin
            if (reg_idx == rxfsi_pkg::REG_IRQ_MASK) begin
                r_irq_mask <= pwdata[rxfsi_pkg::MASK_W-1:0];
            end else begin
                r_half_level <= pwdata[rxfsi_pkg::LEVEL_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_idx == rxfsi_pkg::REG_IRQ_MASK) begin
            prdata = rxfsi_pkg::APB_DW'(r_irq_mask);
        end else begin
            prdata = rxfsi_pkg::APB_DW'(r_half_level);
        end
    end

    assign o_cfg.irq_mask   = r_irq_mask;
    assign o_cfg.half_level = r_half_level;

endmodule

@@ hw/rtl/rxfsi_ctrl.sv @@
// ----------------------------------------------------------------------------
// rxfsi_ctrl
// Pointer, count and flag update, word store access and the result stages.
// ----------------------------------------------------------------------------
module rxfsi_ctrl #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int CW    = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rxfsi_pkg::t_cfg               i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rxfsi_pkg::t_in_item           i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rxfsi_pkg::t_out_item          o_out_item,
    output logic                          o_wr_en,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [rxfsi_pkg::WORD_W-1:0]  o_wr_data,
    output logic                          o_rd_en,
    output logic [AW-1:0]                 o_rd_addr,
    input  logic [rxfsi_pkg::WORD_W-1:0]  i_rd_data
);

    localparam int CMPW = (CW > rxfsi_pkg::LEVEL_W) ? CW : rxfsi_pkg::LEVEL_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(DEPTH - 1);

    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          r_empty, n_empty;
    logic          r_half, n_half;
    logic          r_full, n_full;
    logic          r_ovr, n_ovr;
    logic          r_present, n_present;

    logic                  r_pend_v;
    rxfsi_pkg::t_out_item  r_pend, n_pend;
    logic                  r_out_v;
    rxfsi_pkg::t_out_item  r_out, n_out;

    logic              accept;
    logic              pend_mv;
    logic              ovf;
    logic              do_eval;
    logic              push_ok;
    logic              pop_ok;
    logic              present_out;
    rxfsi_pkg::t_cause cause;

    assign pend_mv    = r_pend_v && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_pend_v || pend_mv;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_count     = r_count;
        n_empty     = r_empty;
        n_half      = r_half;
        n_full      = r_full;
        n_ovr       = r_ovr;
        n_present   = r_present;
        ovf         = 1'b0;
        do_eval     = 1'b0;
        push_ok     = 1'b0;
        pop_ok      = 1'b0;
        present_out = r_present;
        cause       = rxfsi_pkg::CAUSE_NONE;

        case (i_in_item.cmd)
            rxfsi_pkg::CMD_PUSH: begin
                n_present = 1'b1;
                do_eval   = 1'b1;
                if (r_count != DEPTH_C) begin
                    push_ok  = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_wr_ptr = (r_wr_ptr == LAST_C) ? '0 : r_wr_ptr + 1'b1;
                end else begin
                    ovf = 1'b1;
                end
                present_out = n_present;
            end
            rxfsi_pkg::CMD_POP: begin
                do_eval = 1'b1;
                if (r_count != '0) begin
                    pop_ok   = 1'b1;
                    n_count  = r_count - 1'b1;
                    n_rd_ptr = (r_rd_ptr == LAST_C) ? '0 : r_rd_ptr + 1'b1;
                end
            end
            rxfsi_pkg::CMD_POLL: begin
                do_eval = 1'b1;
            end
            rxfsi_pkg::CMD_STATUS: begin
                n_present = 1'b0;
            end
            default: begin
                do_eval = 1'b0;
            end
        endcase

        if (do_eval) begin
            if (ovf) begin
                n_ovr = 1'b1;
                if (!i_cfg.irq_mask[rxfsi_pkg::MASK_FULL]) begin
                    cause = rxfsi_pkg::CAUSE_FULL;
                end
            end else begin
                n_ovr = 1'b0;
                if (n_count == DEPTH_C) begin
                    n_half = 1'b0;
                    if (!r_full) begin
                        n_full = 1'b1;
                        if (!i_cfg.irq_mask[rxfsi_pkg::MASK_FULL]) begin
                            cause = rxfsi_pkg::CAUSE_FULL;
                        end
                    end
                end else if (CMPW'(n_count) >= CMPW'(i_cfg.half_level)) begin
                    n_full = 1'b0;
                    if (!r_half) begin
                        n_half = 1'b1;
                        if (!i_cfg.irq_mask[rxfsi_pkg::MASK_HALF]) begin
                            cause = rxfsi_pkg::CAUSE_HALF;
                        end
                    end
                end else if (n_count == '0) begin
                    n_empty = 1'b1;
                    n_half  = 1'b0;
                    n_full  = 1'b0;
                end else begin
                    n_half = 1'b0;
                    n_full = 1'b0;
                    if (r_empty) begin
                        n_empty = 1'b0;
                        if (!i_cfg.irq_mask[rxfsi_pkg::MASK_NOT_EMPTY]) begin
                            cause = rxfsi_pkg::CAUSE_NOT_EMPTY;
                        end
                    end
                end
            end
        end

        n_pend.word_out     = '0;
        n_pend.word_valid   = pop_ok;
        n_pend.accepted     = push_ok;
        n_pend.flag_empty   = n_empty;
        n_pend.flag_half    = n_half;
        n_pend.flag_full    = n_full;
        n_pend.flag_overrun = n_ovr;
        n_pend.flag_present = present_out;
        n_pend.irq_cause    = cause;
        n_pend.fill_level   = rxfsi_pkg::FILL_W'(n_count);
    end

    always_comb begin
        n_out          = r_pend;
        n_out.word_out = r_pend.word_valid ? i_rd_data : '0;
    end

    assign o_wr_en   = accept && push_ok;
    assign o_wr_addr = r_wr_ptr;
    assign o_wr_data = i_in_item.word_in;
    assign o_rd_en   = accept && pop_ok;
    assign o_rd_addr = r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
            r_empty   <= 1'b1;
            r_half    <= 1'b0;
            r_full    <= 1'b0;
            r_ovr     <= 1'b0;
            r_present <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (accept) begin
                r_wr_ptr  <= n_wr_ptr;
                r_rd_ptr  <= n_rd_ptr;
                r_count   <= n_count;
                r_empty   <= n_empty;
                r_half    <= n_half;
                r_full    <= n_full;
                r_ovr     <= n_ovr;
                r_present <= n_present;
            end
            r_pend_v <= accept || (r_pend_v && !pend_mv);
            r_out_v  <= pend_mv || (r_out_v && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
        if (pend_mv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("held count above depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == DEPTH_C) |-> r_wr_ptr == r_rd_ptr)
        else $error("pointers disagree with count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_count == DEPTH_C)
        else $error("full flag without full count");

    a_half_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_half && r_full))
        else $error("half-full and full set together");

    a_pop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_item.cmd == rxfsi_pkg::CMD_POP && r_count != '0)
            |=> (r_pend_v && r_pend.word_valid))
        else $error("pop of held word not marked valid");

endmodule
